>>> rtl/core/sc5_pkg.sv
package sc5_pkg;

  // field widths fixed by the stream format
  localparam int CH_W       = 8;
  localparam int OUT_COL_W  = 10;
  localparam int OUT_ROW_W  = 12;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // sharpening kernel taps
  localparam int TAP_CENTRE = 15;
  localparam int TAP_CROSS  = 2;
  localparam int TAP_FAR    = 1;

  // divide by 7 for sums up to 4080: (x * 2341) >> 14
  localparam int DIV7_MUL   = 2341;
  localparam int DIV7_SHIFT = 14;

  localparam int CH_MAX = 255;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [CH_W-1:0] pixel_red;
    logic [CH_W-1:0] pixel_green;
    logic [CH_W-1:0] pixel_blue;
    logic [CH_W-1:0] pixel_alpha;
    logic            frame_start;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]      out_red;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_blue;
    logic [CH_W-1:0]      out_alpha;
    logic [OUT_COL_W-1:0] out_col;
    logic [OUT_ROW_W-1:0] out_row;
    logic                 last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } argb_t;

  typedef struct packed {
    logic [FW_W-1:0] frame_width;
    logic [FH_W-1:0] frame_height;
  } cfg_regs_t;

  // everything the kernel stage needs for one pixel
  typedef struct packed {
    argb_t                centre;
    argb_t                left;
    argb_t                right;
    argb_t                up;
    argb_t                down;
    argb_t                far;
    logic                 do_filter;
    logic                 emit_above;
    logic                 emit_px;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row_above;
    logic [OUT_ROW_W-1:0] row_cur;
  } tap_word_t;

endpackage

>>> rtl/core/sc5_ram.sv
module sc5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/sc5_kernel.sv
module sc5_kernel
  import sc5_pkg::*;
(
  input  logic [CH_W-1:0] centre,
  input  logic [CH_W-1:0] left,
  input  logic [CH_W-1:0] right,
  input  logic [CH_W-1:0] up,
  input  logic [CH_W-1:0] down,
  input  logic [CH_W-1:0] far,
  output logic [CH_W-1:0] value
);

  logic [12:0] pos_sum;
  logic [10:0] neg_sum;
  logic [11:0] mag;
  logic [23:0] prod;
  logic [9:0]  quo;

  // negative sums clamp to zero, so only the positive side is divided
  always_comb begin
    pos_sum = 13'(TAP_CENTRE) * 13'(centre) + 13'(TAP_FAR) * 13'(far);
    neg_sum = 11'(TAP_CROSS) * (11'(left) + 11'(right) + 11'(up) + 11'(down));
    mag     = 12'(pos_sum - 13'(neg_sum));
    prod    = 24'(mag) * 24'(DIV7_MUL);
    quo     = 10'(prod >> DIV7_SHIFT);
    if (pos_sum <= 13'(neg_sum)) begin
      value = '0;
    end else if (quo > 10'(CH_MAX)) begin
      value = CH_W'(CH_MAX);
    end else begin
      value = quo[CH_W-1:0];
    end
  end

endmodule

>>> rtl/core/sc5_out_fifo.sv
module sc5_out_fifo
  import sc5_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_cnt,
  input  out_word_t          push_a,
  input  out_word_t          push_b,
  input  logic               pop,
  output out_word_t          head,
  output logic [FIFO_CW-1:0] count
);

  out_word_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_cnt);
      rd_ptr <= rd_ptr + FIFO_AW'(pop);
      count  <= count + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end
  end

  // up to two words per cycle, first word at the tail
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push_b;
    end
  end

  assign head = mem[rd_ptr];

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (5'(count) + 5'(push_cnt)) <= 5'(FIFO_DEPTH))
    else $error("result queue overflow");
`endif

`ifndef SYNTH
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count <= FIFO_CW'(FIFO_DEPTH)) && (FIFO_AW'(count) == FIFO_AW'(wr_ptr - rd_ptr)))
    else $error("queue count and pointers disagree");
`endif

endmodule

>>> rtl/core/sc5_front.sv
module sc5_front
  import sc5_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4095
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  pix,
  input  logic      accept,
  input  cfg_regs_t cfg,
  input  logic      cfg_wr,
  output logic      idle,
  output tap_word_t taps
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [3:0] {
    ST_RUN = 4'b0001,
    ST_R0  = 4'b0010,
    ST_R1  = 4'b0100,
    ST_R2  = 4'b1000
  } fill_state_t;

  fill_state_t st, st_next;

  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;
  logic [COL_W-1:0] col, ncol, c_cur, col_next;
  logic [ROW_W-1:0] row, nrow, r_cur, row_next;
  logic [ROW_W:0]   nrow_x, row_x, r_x, h_x;
  logic [WID_W-1:0] col_x;
  logic             w1, w2, w3;

  argb_t px, p0, p1, recent, rd_eff, t_eff;
  argb_t a_byp_val, t_byp_val, a_dout, t_dout;
  logic  a_byp, t_byp;

  logic             a_re, t_re;
  logic [COL_W-1:0] a_raddr, t_raddr;
  tap_word_t        taps_next;

  function automatic logic [COL_W-1:0] add_mod(input logic [COL_W-1:0] base,
                                               input logic [1:0]       k,
                                               input logic [WID_W-1:0] w);
    logic [WID_W+1:0] t;
    logic [WID_W+1:0] wx;
    wx = (WID_W+2)'(w);
    t  = (WID_W+2)'(base) + (WID_W+2)'(k);
    if (t >= wx) t = t - wx;
    if (t >= wx) t = t - wx;
    if (t >= wx) t = t - wx;
    return COL_W'(t);
  endfunction

  // register values saturated to the supported range
  always_comb begin
    if (cfg.frame_width == '0) begin
      eff_w = WID_W'(1);
    end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      eff_h = HGT_W'(1);
    end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(cfg.frame_height);
    end
  end

  assign w1  = (eff_w == WID_W'(1));
  assign w2  = (eff_w == WID_W'(2));
  assign w3  = (eff_w == WID_W'(3));
  assign h_x = (ROW_W+1)'(eff_h);
  assign px  = '{alpha: pix.pixel_alpha, red: pix.pixel_red,
                 green: pix.pixel_green, blue: pix.pixel_blue};

  // position of the arriving word
  always_comb begin
    if (WID_W'(col) >= eff_w) begin
      ncol   = '0;
      nrow_x = (ROW_W+1)'(row) + (ROW_W+1)'(1);
    end else begin
      ncol   = col;
      nrow_x = (ROW_W+1)'(row);
    end
    if (nrow_x >= h_x) begin
      nrow_x = '0;
    end
    nrow  = ROW_W'(nrow_x);
    c_cur = pix.frame_start ? '0 : ncol;
    r_cur = pix.frame_start ? '0 : nrow;
    r_x   = (ROW_W+1)'(r_cur);

    col_x = WID_W'(c_cur) + WID_W'(1);
    if (col_x >= eff_w) begin
      col_next = '0;
      row_x    = r_x + (ROW_W+1)'(1);
      row_next = (row_x >= h_x) ? '0 : ROW_W'(row_x);
    end else begin
      col_next = COL_W'(col_x);
      row_x    = r_x;
      row_next = r_cur;
    end
  end

  // line window: p0, p1 and the store read cover columns c, c+1, c+2
  assign rd_eff = a_byp ? a_byp_val : a_dout;
  assign t_eff  = t_byp ? t_byp_val : t_dout;

  always_comb begin
    taps_next.centre     = p0;
    taps_next.left       = recent;
    taps_next.right      = p1;
    taps_next.up         = t_eff;
    taps_next.down       = px;
    taps_next.far        = rd_eff;
    taps_next.emit_above = (r_cur != '0);
    taps_next.emit_px    = ((r_x + (ROW_W+1)'(1)) == h_x);
    taps_next.do_filter  = (c_cur >= COL_W'(2))
                        && (((WID_W+1)'(c_cur) + (WID_W+1)'(2)) < (WID_W+1)'(eff_w))
                        && (r_cur >= ROW_W'(3))
                        && ((r_x + (ROW_W+1)'(1)) < h_x);
    taps_next.col        = OUT_COL_W'(c_cur);
    taps_next.row_above  = OUT_ROW_W'(r_cur - ROW_W'(1));
    taps_next.row_cur    = OUT_ROW_W'(r_cur);
  end

  // refill of the window after a register write
  always_comb begin
    st_next = st;
    unique case (st)
      ST_RUN: st_next = ST_RUN;
      ST_R0:  st_next = ST_R1;
      ST_R1:  st_next = ST_R2;
      ST_R2:  st_next = ST_RUN;
      default: st_next = ST_RUN;
    endcase
    if (cfg_wr) begin
      st_next = ST_R0;
    end
  end

  always_comb begin
    a_re    = accept;
    a_raddr = add_mod(c_cur, 2'd3, eff_w);
    t_re    = accept;
    t_raddr = add_mod(c_cur, 2'd1, eff_w);
    unique case (st)
      ST_R0: begin
        a_re    = 1'b1;
        a_raddr = ncol;
        t_re    = 1'b1;
        t_raddr = ncol;
      end
      ST_R1: begin
        a_re    = 1'b1;
        a_raddr = add_mod(ncol, 2'd1, eff_w);
      end
      ST_R2: begin
        a_re    = 1'b1;
        a_raddr = add_mod(ncol, 2'd2, eff_w);
      end
      default: begin
      end
    endcase
  end

  assign idle = (st == ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      st    <= ST_RUN;
      a_byp <= 1'b0;
      t_byp <= 1'b0;
    end else begin
      st <= st_next;
      if (accept) begin
        col   <= col_next;
        row   <= row_next;
        // narrow frames wrap onto the column being written now
        a_byp <= w1 || w3;
        t_byp <= w1;
      end else if (st == ST_R0) begin
        a_byp <= 1'b0;
        t_byp <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      taps      <= taps_next;
      recent    <= p0;
      p0        <= w1 ? px : p1;
      p1        <= (w1 || w2) ? px : rd_eff;
      a_byp_val <= px;
      t_byp_val <= p0;
    end else begin
      unique case (st)
        ST_R1: p0 <= a_dout;
        ST_R2: p1 <= a_dout;
        default: begin
        end
      endcase
    end
  end

  sc5_ram #(
    .WIDTH ($bits(argb_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_above (
    .clk   (clk),
    .we    (accept),
    .waddr (c_cur),
    .wdata (px),
    .re    (a_re),
    .raddr (a_raddr),
    .rdata (a_dout)
  );

  sc5_ram #(
    .WIDTH ($bits(argb_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_two_above (
    .clk   (clk),
    .we    (accept),
    .waddr (c_cur),
    .wdata (p0),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_dout)
  );

`ifndef SYNTH
  a_refill_ends: assert property (@(posedge clk) disable iff (rst)
    (st == ST_R2) && !cfg_wr |=> (st == ST_RUN))
    else $error("window refill did not finish");
`endif

`ifndef SYNTH
  a_col_in_line: assert property (@(posedge clk) disable iff (rst)
    accept |=> (WID_W'(col) < eff_w))
    else $error("column counter left the line");
`endif

endmodule

>>> rtl/core/sharpen_convolution_5x5.sv
// 5x5 sharpening filter on a raster-order ARGB pixel stream.
// pix / pix_valid / pix_ready: one pixel word per handshake, frame_start on
//   the first pixel of a frame. res / res_valid / res_ready: result words,
//   each with its column, line and a last_of_run flag closing the results
//   that one input word caused.
// cfg_we / cfg_index / cfg_data: frame_width (index 0) and frame_height
//   (index 1), written while the block is idle. A write starts a refill
//   of the line window (states R0, R1, R2), during which pix_ready is low.
// Throughput: one word per cycle while pix_ready is high. An input word on
//   line r releases the result for line r-1; words on the last line of a
//   frame release two results, so there the output port limits the input
//   rate. The two line stores are single-read memories, which with the
//   window registers give every kernel tap in one pass.
// Results: a word's results pass the stage register, then the result queue.
// Reset: position goes to column 0, line 0, registers to 640 x 480, queue
//   empty. Line stores are not cleared; the first line of a frame fills them.
// Stalls: an 8-word result queue takes input while res_ready is low. pix_ready
//   is low in a refill, or if the stage word's results plus two more won't fit.
module sharpen_convolution_5x5
  import sc5_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4095
) (
  input  logic                  clk,
  input  logic                  rst,
  input  in_word_t              pix,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  output out_word_t             res,
  output logic                  res_valid,
  input  logic                  res_ready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t          cfg;
  logic               accept;
  logic               front_idle;
  tap_word_t          taps;
  logic               s1_valid;     // taps hold a word for the kernel stage
  logic [CH_W-1:0]    k_red, k_green, k_blue;
  out_word_t          above_word, px_word, push_a, push_b;
  logic [1:0]         push_cnt;
  logic [FIFO_CW-1:0] fifo_count;
  logic               pop;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{frame_width: FRAME_WIDTH_RST, frame_height: FRAME_HEIGHT_RST};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[FH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // keep room for the word in the stage register plus the new one
  assign pix_ready = !rst && front_idle
                  && ((5'(fifo_count) + (s1_valid ? 5'd2 : 5'd0)) <= 5'(FIFO_DEPTH - 2));
  assign accept    = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // position tracking, line stores and tap window
  sc5_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .pix    (pix),
    .accept (accept),
    .cfg    (cfg),
    .cfg_wr (cfg_we),
    .idle   (front_idle),
    .taps   (taps)
  );

  // one kernel per colour channel
  sc5_kernel u_kernel_red (
    .centre (taps.centre.red),
    .left   (taps.left.red),
    .right  (taps.right.red),
    .up     (taps.up.red),
    .down   (taps.down.red),
    .far    (taps.far.red),
    .value  (k_red)
  );

  sc5_kernel u_kernel_green (
    .centre (taps.centre.green),
    .left   (taps.left.green),
    .right  (taps.right.green),
    .up     (taps.up.green),
    .down   (taps.down.green),
    .far    (taps.far.green),
    .value  (k_green)
  );

  sc5_kernel u_kernel_blue (
    .centre (taps.centre.blue),
    .left   (taps.left.blue),
    .right  (taps.right.blue),
    .up     (taps.up.blue),
    .down   (taps.down.blue),
    .far    (taps.far.blue),
    .value  (k_blue)
  );

  // result words: the pixel one line up, then on the last line the pixel itself
  always_comb begin
    above_word.out_red     = taps.do_filter ? k_red   : taps.centre.red;
    above_word.out_green   = taps.do_filter ? k_green : taps.centre.green;
    above_word.out_blue    = taps.do_filter ? k_blue  : taps.centre.blue;
    above_word.out_alpha   = taps.do_filter ? CH_W'(CH_MAX) : taps.centre.alpha;
    above_word.out_col     = taps.col;
    above_word.out_row     = taps.row_above;
    above_word.last_of_run = !taps.emit_px;

    px_word.out_red     = taps.down.red;
    px_word.out_green   = taps.down.green;
    px_word.out_blue    = taps.down.blue;
    px_word.out_alpha   = taps.down.alpha;
    px_word.out_col     = taps.col;
    px_word.out_row     = taps.row_cur;
    px_word.last_of_run = 1'b1;

    push_a   = taps.emit_above ? above_word : px_word;
    push_b   = px_word;
    push_cnt = s1_valid ? (2'(taps.emit_above) + 2'(taps.emit_px)) : 2'd0;
  end

  assign res_valid = (fifo_count != '0);
  assign pop       = res_valid && res_ready;

  sc5_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push_a   (push_a),
    .push_b   (push_b),
    .pop      (pop),
    .head     (res),
    .count    (fifo_count)
  );

endmodule
